[hdl/assert_macros.svh]
// Assertion macros included by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication under an active-low reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[hdl/grf_pkg.sv]
// Request codes and constants of the guest register file.
package grf_pkg;

	localparam logic [2:0] REQ_GPR_RD  = 3'd0;
	localparam logic [2:0] REQ_GPR_WR  = 3'd1;
	localparam logic [2:0] REQ_LANE_RD = 3'd2;
	localparam logic [2:0] REQ_LANE_WR = 3'd3;
	localparam logic [2:0] REQ_SCAL_WR = 3'd4;
	localparam logic [2:0] REQ_FLAG_WR = 3'd5;

	localparam logic [1:0] ESZ_8  = 2'd0;
	localparam logic [1:0] ESZ_16 = 2'd1;
	localparam logic [1:0] ESZ_32 = 2'd2;
	localparam logic [1:0] ESZ_64 = 2'd3;

	localparam logic [63:0] LOW_WORD_MASK = 64'h0000_0000_FFFF_FFFF;

	typedef logic [63:0]  word_t;
	typedef logic [127:0] vreg_t;
	typedef logic [3:0]   flags_t;

endpackage

[hdl/guest_register_file_unit.sv]
// Guest register file: general, stack pointer, vector registers and NZCV flags.
// A request is taken when start is high and busy is low; done strobes its result
// in the cycle after the execute cycle. No new request is taken while busy: the
// memory is read at accept, then modified and written back in the execute state.
// A new start is taken in the cycle done is shown. Asynchronous reset clears the
// per-entry valid bits, stack pointer and flags at once; no clearing pass is run.
module guest_register_file_unit #(
	parameter int NUM_GPRS  = 31,
	parameter int NUM_VREGS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [4:0]  reg_index,
	input  logic        is_zero_reg,
	input  logic        is_stack_ptr,
	input  logic        width_32,
	input  logic [63:0] data_value,
	input  logic [1:0]  element_size,
	input  logic [3:0]  lane_index,
	input  logic [1:0]  flag_select,
	input  logic        flag_bit,
	output logic        done,
	output logic [63:0] read_data,
	output logic [3:0]  flags_now
);

	localparam int GAW = (NUM_GPRS > 1) ? $clog2(NUM_GPRS) : 1;
	localparam int VAW = (NUM_VREGS > 1) ? $clog2(NUM_VREGS) : 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic accept;
	logic exec;

	grf_pkg::word_t gpr_mem [NUM_GPRS];
	grf_pkg::vreg_t vec_mem [NUM_VREGS];
	logic [NUM_GPRS-1:0]  gpr_vld_q;
	logic [NUM_VREGS-1:0] vec_vld_q;

	grf_pkg::word_t  sp_q;
	grf_pkg::flags_t flags_q;

	logic [GAW-1:0] gaddr;
	logic [VAW-1:0] vaddr;
	logic           gpr_in;
	logic           vec_in;

	logic [2:0]     req_type_s1;
	logic           is_zero_reg_s1;
	logic           is_stack_ptr_s1;
	logic           width_32_s1;
	grf_pkg::word_t data_value_s1;
	logic [1:0]     element_size_s1;
	logic [3:0]     lane_index_s1;
	logic [1:0]     flag_select_s1;
	logic           flag_bit_s1;
	logic [GAW-1:0] gaddr_s1;
	logic [VAW-1:0] vaddr_s1;
	logic           gpr_in_s1;
	logic           vec_in_s1;
	logic           gpr_vld_s1;
	logic           vec_vld_s1;
	grf_pkg::word_t gpr_rdata_s1;
	grf_pkg::vreg_t vec_rdata_s1;

	grf_pkg::word_t  gpr_old;
	grf_pkg::vreg_t  vec_old;
	grf_pkg::word_t  lmask;
	logic [3:0]      lane_sel;
	logic [6:0]      lane_off;
	grf_pkg::vreg_t  mask_sh;
	grf_pkg::vreg_t  data_sh;
	grf_pkg::vreg_t  vec_shr;
	grf_pkg::word_t  gpr_wdata;
	grf_pkg::vreg_t  vec_wdata;
	logic            gpr_we;
	logic            sp_we;
	logic            vec_we;
	grf_pkg::word_t  rd_nxt;
	grf_pkg::flags_t flags_nxt;
	logic [1:0]      flag_pos;

	grf_pkg::word_t  read_data_q;
	grf_pkg::flags_t flags_now_q;
	logic            done_q;

	assign busy   = (state_q == S_EXEC);
	assign accept = start && !busy;
	assign exec   = (state_q == S_EXEC);

	assign gaddr  = reg_index[GAW-1:0];
	assign vaddr  = reg_index[VAW-1:0];
	assign gpr_in = ({1'b0, reg_index} < 6'(NUM_GPRS));
	assign vec_in = ({1'b0, reg_index} < 6'(NUM_VREGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= exec;
			case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1     <= req_type;
			is_zero_reg_s1  <= is_zero_reg;
			is_stack_ptr_s1 <= is_stack_ptr;
			width_32_s1     <= width_32;
			data_value_s1   <= data_value;
			element_size_s1 <= element_size;
			lane_index_s1   <= lane_index;
			flag_select_s1  <= flag_select;
			flag_bit_s1     <= flag_bit;
			gaddr_s1        <= gaddr;
			vaddr_s1        <= vaddr;
			gpr_in_s1       <= gpr_in;
			vec_in_s1       <= vec_in;
			gpr_vld_s1      <= gpr_in && gpr_vld_q[gaddr];
			vec_vld_s1      <= vec_in && vec_vld_q[vaddr];
		end
	end

	always_ff @(posedge clk) begin
		if (exec && gpr_we) gpr_mem[gaddr_s1] <= gpr_wdata;
		if (accept) gpr_rdata_s1 <= gpr_mem[gaddr];
	end

	always_ff @(posedge clk) begin
		if (exec && vec_we) vec_mem[vaddr_s1] <= vec_wdata;
		if (accept) vec_rdata_s1 <= vec_mem[vaddr];
	end

	always_comb begin
		gpr_old = gpr_vld_s1 ? gpr_rdata_s1 : '0;
		vec_old = (vec_vld_s1 && req_type_s1 != grf_pkg::REQ_SCAL_WR) ? vec_rdata_s1 : '0;
		lane_sel = (req_type_s1 == grf_pkg::REQ_SCAL_WR) ? 4'd0 : lane_index_s1;
		case (element_size_s1)
			grf_pkg::ESZ_8: begin
				lmask    = 64'h0000_0000_0000_00FF;
				lane_off = {lane_sel[3:0], 3'b000};
			end
			grf_pkg::ESZ_16: begin
				lmask    = 64'h0000_0000_0000_FFFF;
				lane_off = {lane_sel[2:0], 4'b0000};
			end
			grf_pkg::ESZ_32: begin
				lmask    = 64'h0000_0000_FFFF_FFFF;
				lane_off = {lane_sel[1:0], 5'b00000};
			end
			default: begin
				lmask    = 64'hFFFF_FFFF_FFFF_FFFF;
				lane_off = {lane_sel[0], 6'b000000};
			end
		endcase
		mask_sh   = {64'd0, lmask} << lane_off;
		data_sh   = {64'd0, data_value_s1 & lmask} << lane_off;
		vec_shr   = vec_old >> lane_off;
		vec_wdata = (vec_old & ~mask_sh) | data_sh;
		gpr_wdata = width_32_s1 ? (data_value_s1 & grf_pkg::LOW_WORD_MASK) : data_value_s1;

		gpr_we    = 1'b0;
		sp_we     = 1'b0;
		vec_we    = 1'b0;
		rd_nxt    = '0;
		flags_nxt = flags_q;
		flag_pos  = 2'd3 - flag_select_s1;
		case (req_type_s1)
			grf_pkg::REQ_GPR_RD: begin
				if (is_zero_reg_s1) rd_nxt = '0;
				else if (is_stack_ptr_s1) rd_nxt = sp_q;
				else rd_nxt = gpr_old;
				if (width_32_s1) rd_nxt = rd_nxt & grf_pkg::LOW_WORD_MASK;
			end
			grf_pkg::REQ_GPR_WR: begin
				if (!is_zero_reg_s1) begin
					if (is_stack_ptr_s1) sp_we = 1'b1;
					else gpr_we = gpr_in_s1;
				end
			end
			grf_pkg::REQ_LANE_RD: begin
				if (vec_in_s1) rd_nxt = vec_shr[63:0] & lmask;
			end
			grf_pkg::REQ_LANE_WR, grf_pkg::REQ_SCAL_WR: begin
				vec_we = vec_in_s1;
			end
			grf_pkg::REQ_FLAG_WR: begin
				flags_nxt[flag_pos] = flag_bit_s1;
			end
			default: begin
				rd_nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpr_vld_q   <= '0;
			vec_vld_q   <= '0;
			sp_q        <= '0;
			flags_q     <= '0;
			flags_now_q <= '0;
		end else if (exec) begin
			if (gpr_we) gpr_vld_q[gaddr_s1] <= 1'b1;
			if (vec_we) vec_vld_q[vaddr_s1] <= 1'b1;
			if (sp_we) sp_q <= gpr_wdata;
			flags_q     <= flags_nxt;
			flags_now_q <= flags_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) read_data_q <= rd_nxt;
	end

	assign done      = done_q;
	assign read_data = read_data_q;
	assign flags_now = flags_now_q;

endmodule

[hdl/grf_checker.sv]
// Port-level checker for the guest register file, bound to guest_register_file_unit.
`include "assert_macros.svh"

module grf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  req_type,
	input logic [63:0] read_data
);

	logic wr_req;

	assign wr_req = req_type inside {grf_pkg::REQ_GPR_WR, grf_pkg::REQ_LANE_WR,
		grf_pkg::REQ_SCAL_WR, grf_pkg::REQ_FLAG_WR};

	`ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`ASSERT_NXT(a_busy_done, clk, arst_n, busy, done && !busy)
	`ASSERT_IMP(a_done_origin, clk, arst_n, done, $past(start && !busy, 2))
	`ASSERT_IMP(a_write_zero, clk, arst_n, done && $past(wr_req, 2), read_data == 64'd0)

endmodule

bind guest_register_file_unit grf_checker u_grf_checker (.*);
